/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/llre_pkg.sv */
package llre_pkg;

    // Command codes.
    localparam logic [2:0] MODE_BEFORE  = 3'd0;
    localparam logic [2:0] MODE_AFTER   = 3'd1;
    localparam logic [2:0] MODE_SWAP    = 3'd2;
    localparam logic [2:0] MODE_TOGGLE  = 3'd3;
    localparam logic [2:0] MODE_INIT    = 3'd4;
    localparam logic [2:0] MODE_REPORT  = 3'd5;

    localparam int MODE_W  = 3;
    localparam int BOX_W   = 11;
    localparam int SUM_W   = 20;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [BOX_W-1:0]  first_box;
        logic [BOX_W-1:0]  second_box;
    } t_cmd;

    typedef struct packed {
        logic [SUM_W-1:0] odd_position_sum;
        logic             bad_command;
    } t_res;

endpackage

/* rtl/llre_if.sv */
interface llre_cmd_if import llre_pkg::*; ();
    logic valid;
    logic ready;
    t_cmd data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface llre_res_if import llre_pkg::*; ();
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface llre_cfg_if import llre_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [BOX_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/llre_ram.sv */
module llre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/linked_list_reorder_engine.sv */
// A toggle, rejected or unused command goes from the check state to done; a move or swap
// reads the links of both boxes, then makes up to four link writes.
// Initialize writes one entry per cycle; report walks one link at a time, waiting on the
// registered memory read for each link.
// One command is in work at a time; the next is taken once the result has left the output.
// Synchronous active-low reset clears the reverse flag, sets box count 1, idles the sequencer.
module linked_list_reorder_engine import llre_pkg::*; #(
    parameter int MAX_BOXES = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    llre_cmd_if.sink     cmd,
    llre_cfg_if.sink     cfg,
    llre_res_if.source   res
);
    localparam int AW = $clog2(MAX_BOXES + 1);
    localparam int DEPTH = MAX_BOXES + 1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHECK = 7'b0000010,
        S_READ  = 7'b0000100,
        S_WRITE = 7'b0001000,
        S_INIT  = 7'b0010000,
        S_WALK  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [BOX_W-1:0] r_count;
    logic r_rev;
    t_cmd r_cmd;
    logic [AW-1:0] r_x, r_y;
    logic [AW-1:0] r_lx, r_rx, r_ly, r_ry;
    logic [2:0] r_step;
    logic [AW:0] r_idx;
    logic [AW-1:0] r_cur;
    logic r_phase;
    logic [SUM_W-1:0] r_sum;
    logic r_out_valid;
    t_res r_out;

    // Effective n saturated into 1..MAX_BOXES.
    logic [AW:0] w_n;
    always_comb begin
        if (r_count == '0) begin
            w_n = (AW+1)'(1);
        end else if (32'(r_count) > MAX_BOXES) begin
            w_n = (AW+1)'(MAX_BOXES);
        end else begin
            w_n = (AW+1)'(r_count);
        end
    end

    // Memory ports.
    logic          w_nwe, w_pwe;
    logic [AW-1:0] w_nwa, w_pwa, w_nwd, w_pwd, w_ra, w_nrd, w_prd;

    llre_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_next (
        .i_clk(i_clk), .i_we(w_nwe), .i_waddr(w_nwa), .i_wdata(w_nwd),
        .i_raddr(w_ra), .o_rdata(w_nrd)
    );
    llre_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_prev (
        .i_clk(i_clk), .i_we(w_pwe), .i_waddr(w_pwa), .i_wdata(w_pwd),
        .i_raddr(w_ra), .o_rdata(w_prd)
    );

    function automatic logic [AW-1:0] clip(input logic [AW-1:0] v);
        return (32'(v) <= MAX_BOXES) ? v : '0;
    endfunction

    // Derived move/swap plan from the four neighbors.
    logic w_swap_adj_rev, w_after, w_skip;
    logic [AW-1:0] w_a, w_b, w_la, w_ra_, w_lb, w_rb;
    logic [2:0] w_nj;
    logic [AW-1:0] w_jl, w_jr;
    always_comb begin
        w_swap_adj_rev = (r_ry == r_x);
        w_a = w_swap_adj_rev ? r_y : r_x;
        w_b = w_swap_adj_rev ? r_x : r_y;
        w_la = w_swap_adj_rev ? r_ly : r_lx;
        w_ra_ = w_swap_adj_rev ? r_ry : r_rx;
        w_lb = w_swap_adj_rev ? r_lx : r_ly;
        w_rb = w_swap_adj_rev ? r_rx : r_ry;
        w_after = r_cmd.mode[0] ^ r_rev;
        w_skip = (r_cmd.mode != MODE_SWAP) && (w_after ? (r_ry == r_x) : (r_ly == r_x));
        w_nj = 3'd3;
        w_jl = '0;
        w_jr = '0;
        if (r_cmd.mode == MODE_SWAP) begin
            if (w_ra_ == w_b) begin
                w_nj = 3'd3;
                case (r_step)
                    3'd0: begin w_jl = w_la; w_jr = w_b; end
                    3'd1: begin w_jl = w_b; w_jr = w_a; end
                    default: begin w_jl = w_a; w_jr = w_rb; end
                endcase
            end else begin
                w_nj = 3'd4;
                case (r_step)
                    3'd0: begin w_jl = w_la; w_jr = w_b; end
                    3'd1: begin w_jl = w_b; w_jr = w_ra_; end
                    3'd2: begin w_jl = w_lb; w_jr = w_a; end
                    default: begin w_jl = w_a; w_jr = w_rb; end
                endcase
            end
        end else if (w_after) begin
            case (r_step)
                3'd0: begin w_jl = r_lx; w_jr = r_rx; end
                3'd1: begin w_jl = r_x; w_jr = r_ry; end
                default: begin w_jl = r_y; w_jr = r_x; end
            endcase
        end else begin
            case (r_step)
                3'd0: begin w_jl = r_lx; w_jr = r_rx; end
                3'd1: begin w_jl = r_ly; w_jr = r_x; end
                default: begin w_jl = r_x; w_jr = r_y; end
            endcase
        end
    end

    // Memory control.
    always_comb begin
        w_nwe = 1'b0; w_pwe = 1'b0;
        w_nwa = w_jl; w_nwd = w_jr; w_pwa = w_jr; w_pwd = w_jl;
        w_ra = r_x;
        case (r_state)
            S_READ: w_ra = r_step[0] ? r_y : r_x;
            S_WRITE: begin
                w_nwe = !w_skip;
                w_pwe = !w_skip;
            end
            S_INIT: begin
                w_nwe = 1'b1;
                w_pwe = 1'b1;
                w_nwa = r_idx[AW-1:0];
                w_pwa = r_idx[AW-1:0];
                w_nwd = (r_idx == w_n) ? '0 : AW'(r_idx + 1'b1);
                w_pwd = (r_idx == '0) ? w_n[AW-1:0] : AW'(r_idx - 1'b1);
            end
            S_WALK: w_ra = r_cur;
            default: w_ra = r_x;
        endcase
    end

    logic w_bad;
    assign w_bad = (r_cmd.first_box == '0) || ({1'b0, r_cmd.first_box} > 12'(w_n)) ||
                   (r_cmd.second_box == '0) || ({1'b0, r_cmd.second_box} > 12'(w_n)) ||
                   (r_cmd.first_box == r_cmd.second_box);

    assign cmd.ready = (r_state == S_IDLE) && !r_out_valid;
    assign cfg.ready = 1'b1;
    assign res.valid = r_out_valid;
    assign res.data  = r_out;

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (cmd.valid && cmd.ready) n_state = S_CHECK;
            S_CHECK: begin
                if (r_cmd.mode <= MODE_SWAP) begin
                    n_state = w_bad ? S_DONE : S_READ;
                end else if (r_cmd.mode == MODE_INIT) begin
                    n_state = S_INIT;
                end else if (r_cmd.mode == MODE_REPORT) begin
                    n_state = S_WALK;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_READ:  if (r_step == 3'd2) n_state = S_WRITE;
            S_WRITE: if (w_skip || r_step == w_nj - 3'd1) n_state = S_DONE;
            S_INIT:  if (r_idx == w_n) n_state = S_DONE;
            S_WALK:  if (r_phase && r_idx == w_n - 1'b1) n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= BOX_W'(1);
            r_rev <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg.valid) r_count <= cfg.data;
            if (res.valid && res.ready) r_out_valid <= 1'b0;
            if (r_state == S_CHECK && r_cmd.mode == MODE_TOGGLE) r_rev <= !r_rev;
            if (r_state == S_INIT) r_rev <= 1'b0;
            if (r_state == S_DONE) r_out_valid <= 1'b1;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_cmd <= cmd.data;
                r_x <= AW'(cmd.data.first_box);
                r_y <= AW'(cmd.data.second_box);
            end
            S_CHECK: begin
                r_step <= '0;
                r_idx <= '0;
                r_cur <= '0;
                r_phase <= 1'b0;
                r_sum <= '0;
                r_out.bad_command <= (r_cmd.mode <= MODE_SWAP) && w_bad;
                r_out.odd_position_sum <= '0;
            end
            S_READ: begin
                // Read x at step 0, y at step 1; the registered data is captured at the following step.
                if (r_step == 3'd1) begin
                    r_lx <= clip(w_prd); r_rx <= clip(w_nrd);
                end
                if (r_step == 3'd2) begin
                    r_ly <= clip(w_prd); r_ry <= clip(w_nrd);
                    r_step <= '0;
                end else begin
                    r_step <= r_step + 3'd1;
                end
            end
            S_WRITE: r_step <= r_step + 3'd1;
            S_INIT: r_idx <= r_idx + 1'b1;
            S_WALK: begin
                r_phase <= !r_phase;
                if (r_phase) begin
                    r_cur <= clip(r_rev ? w_prd : w_nrd);
                    r_idx <= r_idx + 1'b1;
                    if (!r_idx[0]) r_sum <= r_sum + SUM_W'(clip(r_rev ? w_prd : w_nrd));
                end
            end
            S_DONE: if (r_cmd.mode == MODE_REPORT) r_out.odd_position_sum <= r_sum;
            default: r_step <= r_step;
        endcase
    end
endmodule

/* rtl/llre_checker.sv */
`include "assert_macros.svh"

module llre_checker import llre_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic cmd_valid,
    input logic cmd_ready,
    input logic res_valid,
    input logic res_ready,
    input t_res res_data
);
    // A result holds while it waits.
    `CHK_NEXT(a_res_hold, i_clk, i_rst_n, res_valid && !res_ready, res_valid && $stable(res_data), "result dropped or changed while stalled")
    // No new command while a result waits.
    `CHK_IMPLY(a_no_take, i_clk, i_rst_n, res_valid, !cmd_ready, "command taken with result pending")
    // A rejected command carries no sum.
    `CHK_IMPLY(a_bad_zero, i_clk, i_rst_n, res_valid && res_data.bad_command, res_data.odd_position_sum == '0, "rejected command with sum")
    // Accepting a command drops ready.
    `CHK_NEXT(a_one_cmd, i_clk, i_rst_n, cmd_valid && cmd_ready, !cmd_ready, "two commands in flight")
endmodule

bind linked_list_reorder_engine llre_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .cmd_valid(cmd.valid), .cmd_ready(cmd.ready),
    .res_valid(res.valid), .res_ready(res.ready), .res_data(res.data)
);

/* tb/linked_list_reorder_engine_tb.sv */
module linked_list_reorder_engine_tb;
    import llre_pkg::*;

    localparam int MAX_N = 1024;
    localparam int CYCLE_LIMIT = 2000000;

    logic i_clk;
    logic i_rst_n;

    llre_cmd_if cmd_ch ();
    llre_res_if res_ch ();
    llre_cfg_if cfg_ch ();

    linked_list_reorder_engine #(.MAX_BOXES(MAX_N)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .cmd    (cmd_ch.sink),
        .cfg    (cfg_ch.sink),
        .res    (res_ch.source)
    );

    // Shadow copy of the link tables, reverse flag and box count.
    int unsigned link_next [0:MAX_N];
    int unsigned link_prev [0:MAX_N];
    bit          shadow_reversed;
    int unsigned shadow_count;
    t_res        expected_results[$];
    int          mismatch_count;
    int          cycle_count;
    bit          send_gaps;
    bit          recv_gaps;

    // Clock generation.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Global timeout.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("linked_list_reorder_engine_tb: done, errors");
            $finish;
        end
    end

    function automatic int unsigned eff_count();
        if (shadow_count < 1) return 1;
        if (shadow_count > MAX_N) return MAX_N;
        return shadow_count;
    endfunction

    function automatic void link_pair(int unsigned l, int unsigned r);
        link_next[l] = r;
        link_prev[r] = l;
    endfunction

    // Swap two boxes in the shadow list, adjacent or not.
    function automatic void swap_boxes(int unsigned a, int unsigned b);
        int unsigned t, la, ra, lb, rb;
        if (link_next[b] == a) begin
            t = a;
            a = b;
            b = t;
        end
        la = link_prev[a];
        ra = link_next[a];
        lb = link_prev[b];
        rb = link_next[b];
        if (ra == b) begin
            link_pair(la, b);
            link_pair(b, a);
            link_pair(a, rb);
        end else begin
            link_pair(la, b);
            link_pair(b, ra);
            link_pair(lb, a);
            link_pair(a, rb);
        end
    endfunction

    // Apply one command to the shadow state and return its result.
    function automatic t_res apply_command(t_cmd c);
        t_res r;
        int unsigned n, x, y, lx, rx, ly, ry, cur;
        bit after;
        logic [SUM_W-1:0] total;
        n = eff_count();
        x = c.first_box;
        y = c.second_box;
        total = '0;
        r = '0;
        if (c.mode == MODE_BEFORE || c.mode == MODE_AFTER || c.mode == MODE_SWAP) begin
            if (x < 1 || x > n || y < 1 || y > n || x == y) begin
                r.bad_command = 1'b1;
            end else if (c.mode == MODE_SWAP) begin
                swap_boxes(x, y);
            end else begin
                lx = link_prev[x];
                rx = link_next[x];
                ly = link_prev[y];
                ry = link_next[y];
                after = (c.mode == MODE_AFTER) ^ shadow_reversed;
                if (after) begin
                    if (ry != x) begin
                        link_pair(lx, rx);
                        link_pair(x, ry);
                        link_pair(y, x);
                    end
                end else if (ly != x) begin
                    link_pair(lx, rx);
                    link_pair(ly, x);
                    link_pair(x, y);
                end
            end
        end else if (c.mode == MODE_TOGGLE) begin
            shadow_reversed = !shadow_reversed;
        end else if (c.mode == MODE_INIT) begin
            link_next[0] = 1;
            link_prev[0] = n;
            for (int i = 1; i <= n; i++) begin
                link_next[i] = i + 1;
                link_prev[i] = i - 1;
            end
            link_next[n] = 0;
            shadow_reversed = 1'b0;
        end else if (c.mode == MODE_REPORT) begin
            cur = 0;
            for (int p = 1; p <= n; p++) begin
                cur = shadow_reversed ? link_prev[cur] : link_next[cur];
                if (p % 2 == 1) total = total + cur[SUM_W-1:0];
            end
        end
        r.odd_position_sum = total;
        return r;
    endfunction

    // Send one command transaction and record its expected result.
    // Valid stays high into the next call unless the sender idles or drains.
    task automatic send_command(logic [2:0] mode, int unsigned x, int unsigned y);
        t_cmd c;
        c.mode = mode;
        c.first_box = x[BOX_W-1:0];
        c.second_box = y[BOX_W-1:0];
        while (send_gaps && $urandom_range(99) < 25) begin
            cmd_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data <= c;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        expected_results.push_back(apply_command(c));
        @(negedge i_clk);
    endtask

    // Wait until the block is idle with nothing outstanding.
    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    // Write the box count register while the block is idle.
    task automatic write_count(int unsigned value);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= value[BOX_W-1:0];
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        shadow_count = value & 11'h7FF;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Result receiver with random backpressure.
    always @(negedge i_clk) begin
        res_ch.ready <= !(recv_gaps && $urandom_range(99) < 25);
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_res got, exp_r;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = res_ch.data;
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result sum=%0d bad=%0b",
                             got.odd_position_sum, got.bad_command);
            end else begin
                exp_r = expected_results.pop_front();
                if (got !== exp_r) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected sum=%0d bad=%0b, got sum=%0d bad=%0b",
                                 exp_r.odd_position_sum, exp_r.bad_command,
                                 got.odd_position_sum, got.bad_command);
                end
            end
        end
    end

    function automatic int unsigned pick_box(int unsigned n);
        return $urandom_range(n, 1);
    endfunction

    // Small list: every command, the range limits, skipped moves and swaps.
    task automatic test_directed_small();
        write_count(5);
        send_command(MODE_INIT, 0, 0);
        send_command(MODE_REPORT, 0, 0);
        send_command(MODE_BEFORE, 0, 2);
        send_command(MODE_AFTER, 6, 2);
        send_command(MODE_SWAP, 3, 3);
        send_command(MODE_BEFORE, 2047, 2047);
        send_command(MODE_BEFORE, 1, 2);
        send_command(MODE_AFTER, 2, 1);
        send_command(MODE_SWAP, 2, 3);
        send_command(MODE_SWAP, 5, 1);
        send_command(MODE_REPORT, 0, 0);
        send_command(MODE_TOGGLE, 2047, 2047);
        send_command(MODE_BEFORE, 5, 4);
        send_command(MODE_AFTER, 1, 5);
        send_command(MODE_REPORT, 0, 0);
        send_command(3'd6, 1, 2);
        send_command(3'd7, 1, 2);
        send_command(MODE_INIT, 0, 0);
        send_command(MODE_REPORT, 0, 0);
    endtask

    // Extremes of the box count, including saturation of large values.
    task automatic test_count_extremes();
        write_count(1);
        send_command(MODE_INIT, 0, 0);
        send_command(MODE_SWAP, 1, 1);
        send_command(MODE_REPORT, 0, 0);
        write_count(0);
        send_command(MODE_REPORT, 0, 0);
        write_count(2047);
        send_command(MODE_INIT, 0, 0);
        send_command(MODE_SWAP, 1, 1024);
        send_command(MODE_AFTER, 1024, 1);
        send_command(MODE_BEFORE, 1025, 3);
        send_command(MODE_REPORT, 0, 0);
        send_command(MODE_TOGGLE, 0, 0);
        send_command(MODE_REPORT, 0, 0);
        // Shrinking n keeps the links; report walks only the new n links.
        write_count(4);
        send_command(MODE_REPORT, 0, 0);
        send_command(MODE_INIT, 0, 0);
        send_command(MODE_REPORT, 0, 0);
    endtask

    // Random commands on a list of n boxes, with box numbers mostly drawn from 1..n.
    task automatic test_random(int unsigned items, int unsigned n);
        int unsigned sel;
        logic [2:0] m;
        write_count(n);
        send_command(MODE_INIT, 0, 0);
        for (int i = 0; i < items; i++) begin
            sel = $urandom_range(99);
            if (sel < 70) m = 3'($urandom_range(2));
            else if (sel < 80) m = MODE_TOGGLE;
            else if (sel < 92) m = MODE_REPORT;
            else if (sel < 95) m = MODE_INIT;
            else m = 3'($urandom_range(7, 6));
            if ($urandom_range(9) == 0)
                send_command(m, $urandom_range(2047), $urandom_range(2047));
            else
                send_command(m, pick_box(n), pick_box(n));
            // Sender pause until every result is back.
            if (i == items / 2) wait_drained();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        res_ch.ready = 1'b0;
        shadow_reversed = 1'b0;
        shadow_count = 1;
        mismatch_count = 0;
        cycle_count = 0;
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
        for (int i = 0; i <= MAX_N; i++) begin
            link_next[i] = 0;
            link_prev[i] = 0;
        end
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_small();
        test_count_extremes();
        test_random(200, 8);
        // Stretch with no idling on either side.
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        test_random(100, 3);
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
        test_random(150, 2);
        test_random(60, 40);
        test_random(10, 2047);

        wait_drained();
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("linked_list_reorder_engine_tb: done, clean");
        else
            $display("linked_list_reorder_engine_tb: done, errors");
        $finish;
    end

endmodule
